FILE: design/stsi_pkg.sv
// ---------------------------------------------------------------------------
// stsi_pkg: shared types and constants of the sorted key table
// table size, derived widths, request kinds and the key store access request
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package stsi_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int POS_W       = 7;
  localparam int TOTAL_W     = 8;

  // request kinds
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // one write and one read of the key store per cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [KEY_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

endpackage

`default_nettype wire

FILE: design/sorted_table_search_insert.sv
// ---------------------------------------------------------------------------
// sorted_table_search_insert: sorted table of signed keys with search/insert
// binary search over an ascending key store, insert in sorted place on a
// load or on a search miss, refused with a full flag when the table is full
// ---------------------------------------------------------------------------
//
//  channel   | dir | handshake                       | payload
//  ----------+-----+---------------------------------+--------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready   | tdata key_value, tuser func
//  m_axis    | out | m_axis_tvalid / m_axis_tready   | tdata position, entry_total
//            |     |                                 | tuser found, inserted, full
//
//  one request at a time: each probe of the binary search reads the store,
//  then compares the key with the stored key; an insert then moves the keys
//  above its place up by one, one key a cycle through the store's read and
//  write ports, then writes the new key in its place
//  s_axis_tready is high only while the sequencer is idle; a result held in
//  the output register does not stop the next request from being taken, but
//  the sequencer waits at the end of a request until that register is free
//  reset empties the table (count to zero); the store itself is not cleared
//
`timescale 1ns / 1ps
`default_nettype none

module sorted_table_search_insert (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] key_value
  input  wire logic [0:0]  s_axis_tuser,   // [0] func
  // result
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [6:0] position, [14:7] entry_total, [15] zero
  output logic [2:0]       m_axis_tuser    // [0] found, [1] inserted, [2] table_full
);
  import stsi_pkg::*;

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PRB_RD = 3'd1;  // pick midpoint, read the store
  localparam logic [2:0] ST_PRB_CM = 3'd2;  // compare key with the stored key
  localparam logic [2:0] ST_SHIFT  = 3'd3;  // move keys up one place
  localparam logic [2:0] ST_PUT    = 3'd4;  // write the new key
  localparam logic [2:0] ST_RESULT = 3'd5;  // hand result to the output register

  logic [2:0]       state_q, state_d;
  logic             func_q, func_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [CNT_W-1:0] lo_q, lo_d;
  logic [CNT_W-1:0] hi_q, hi_d;        // exclusive upper bound
  logic [IDX_W-1:0] mid_q, mid_d;
  logic [IDX_W-1:0] pos_q, pos_d;
  logic [CNT_W-1:0] ptr_q, ptr_d;      // next slot to fill during the shift
  logic             pend_q, pend_d;    // read data waiting to be written
  logic [IDX_W-1:0] waddr_q, waddr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             found_q, found_d;
  logic             ins_q, ins_d;
  logic             full_q, full_d;

  // output register
  logic             m_valid_q;
  logic [15:0]      m_data_q;
  logic [2:0]       m_user_q;
  logic             m_load;

  ram_req_t         ram_req;
  logic [KEY_W-1:0] ram_rdata;

  // shared compare unit
  logic             key_eq;
  logic             key_lt;
  logic [CNT_W:0]   mid_sum;

  stsi_key_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  assign key_eq = (ram_rdata == key_q);
  assign key_lt = ($signed(key_q) < $signed(ram_rdata));

  // a search request floors the midpoint of lo and the inclusive upper bound
  // (hi - 1), a load request floors that of lo and the exclusive bound hi
  always_comb begin
    if (func_q == FUNC_SEARCH) begin
      mid_sum = ({1'b0, lo_q} + {1'b0, hi_q}) - (CNT_W+1)'(1);
    end else begin
      mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_load        = (state_q == ST_RESULT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    func_d  = func_q;
    key_d   = key_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    mid_d   = mid_q;
    pos_d   = pos_q;
    ptr_d   = ptr_q;
    pend_d  = pend_q;
    waddr_d = waddr_q;
    count_d = count_q;
    found_d = found_q;
    ins_d   = ins_q;
    full_d  = full_q;

    ram_req.we    = 1'b0;
    ram_req.waddr = waddr_q;
    ram_req.wdata = ram_rdata;
    ram_req.raddr = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          func_d  = s_axis_tuser[0];
          key_d   = s_axis_tdata;
          lo_d    = '0;
          hi_d    = count_q;
          found_d = 1'b0;
          ins_d   = 1'b0;
          full_d  = 1'b0;
          pos_d   = '0;
          state_d = ST_PRB_RD;
        end
      end

      ST_PRB_RD: begin
        if (lo_q < hi_q) begin
          mid_d         = mid_sum[IDX_W:1];
          ram_req.raddr = mid_sum[IDX_W:1];
          state_d       = ST_PRB_CM;
        end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
          // no room: refuse the insert
          full_d  = 1'b1;
          pos_d   = '0;
          state_d = ST_RESULT;
        end else begin
          // lo is the first place holding a key greater than the new one
          pos_d   = lo_q[IDX_W-1:0];
          ptr_d   = count_q;
          pend_d  = 1'b0;
          state_d = ST_SHIFT;
        end
      end

      ST_PRB_CM: begin
        if ((func_q == FUNC_SEARCH) && key_eq) begin
          found_d = 1'b1;
          pos_d   = mid_q;
          state_d = ST_RESULT;
        end else begin
          if (key_lt) begin
            hi_d = CNT_W'(mid_q);
          end else begin
            lo_d = CNT_W'(mid_q) + CNT_W'(1);
          end
          state_d = ST_PRB_RD;
        end
      end

      ST_SHIFT: begin
        // write the key read last cycle one place up, read the next one down
        ram_req.we = pend_q;
        if (ptr_q == CNT_W'(pos_q)) begin
          pend_d  = 1'b0;
          state_d = ST_PUT;
        end else begin
          ram_req.raddr = IDX_W'(ptr_q - CNT_W'(1));
          waddr_d       = ptr_q[IDX_W-1:0];
          ptr_d         = ptr_q - CNT_W'(1);
          pend_d        = 1'b1;
        end
      end

      ST_PUT: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = pos_q;
        ram_req.wdata = key_q;
        count_d       = count_q + CNT_W'(1);
        ins_d         = 1'b1;
        state_d       = ST_RESULT;
      end

      ST_RESULT: begin
        if (m_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      pend_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      pend_q  <= pend_d;
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // payload and working registers
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    key_q   <= key_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    mid_q   <= mid_d;
    pos_q   <= pos_d;
    ptr_q   <= ptr_d;
    waddr_q <= waddr_d;
    found_q <= found_d;
    ins_q   <= ins_d;
    full_q  <= full_d;
    if (m_load) begin
      m_data_q <= {1'b0, TOTAL_W'(count_q), POS_W'(pos_q)};
      m_user_q <= {full_q, ins_q, found_q};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

`default_nettype wire

FILE: design/stsi_key_ram.sv
// ---------------------------------------------------------------------------
// stsi_key_ram: key store of the sorted table
// one write port and one read port, read data registered
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module stsi_key_ram (
  input  wire logic                   clk_i,
  input  wire stsi_pkg::ram_req_t     req_i,
  output logic [stsi_pkg::KEY_W-1:0]  rdata_o
);
  import stsi_pkg::*;

  logic [KEY_W-1:0] mem_q [TABLE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[req_i.raddr];
  end

endmodule

`default_nettype wire
